// ----- hdl/acomp_pkg.sv -----
// shared constants and payload types for the source-over compositor
`default_nettype none

package acomp_pkg;

    localparam int CH_W       = 8;
    localparam int ALPHA_W    = 16;
    localparam int COEF_W     = 15;
    localparam int NUM_W      = 31;
    localparam int PROD_W     = 23;
    localparam int DIV_STAGES = COEF_W;

    localparam logic [CH_W-1:0]    FULL_ALPHA = 8'd255;
    localparam logic [CH_W-1:0]    HALF_STEP  = 8'h80;
    localparam int                 FRAC_BITS  = 7;
    // 255 * 128, the full-coverage weight
    localparam logic [COEF_W-1:0]  COEF_FULL  = 15'd32640;
    // 255 * 255 * 128, numerator scale applied to source alpha
    localparam logic [PROD_W-1:0]  NUM_SCALE  = 23'd8323200;
    // half of one output step at the accumulator scale
    localparam logic [PROD_W-1:0]  ROUND_BIAS = PROD_W'(HALF_STEP) << FRAC_BITS;

    // payload carried through the divider stages
    typedef struct packed {
        logic [CH_W-1:0]    s_red;
        logic [CH_W-1:0]    s_green;
        logic [CH_W-1:0]    s_blue;
        logic [CH_W-1:0]    d_red;
        logic [CH_W-1:0]    d_green;
        logic [CH_W-1:0]    d_blue;
        logic [CH_W-1:0]    d_alpha;
        logic [ALPHA_W-1:0] outa;
        logic               transparent;
        logic [COEF_W-1:0]  num_low;
        logic [ALPHA_W-1:0] rem;
        logic [COEF_W-1:0]  quo;
    } stage_t;

endpackage

`default_nettype wire

// ----- hdl/acomp_ifs.sv -----
// pixel pair and result channel interfaces
`default_nettype none

interface acomp_pix_if;
    logic                      valid;
    logic                      ready;
    logic [acomp_pkg::CH_W-1:0] src_red;
    logic [acomp_pkg::CH_W-1:0] src_green;
    logic [acomp_pkg::CH_W-1:0] src_blue;
    logic [acomp_pkg::CH_W-1:0] src_opacity;
    logic [acomp_pkg::CH_W-1:0] dst_red;
    logic [acomp_pkg::CH_W-1:0] dst_green;
    logic [acomp_pkg::CH_W-1:0] dst_blue;
    logic [acomp_pkg::CH_W-1:0] dst_alpha;

    modport source (
        output valid, src_red, src_green, src_blue, src_opacity,
        output dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );
    modport sink (
        input  valid, src_red, src_green, src_blue, src_opacity,
        input  dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

interface acomp_res_if;
    logic                      valid;
    logic                      ready;
    logic [acomp_pkg::CH_W-1:0] out_red;
    logic [acomp_pkg::CH_W-1:0] out_green;
    logic [acomp_pkg::CH_W-1:0] out_blue;
    logic [acomp_pkg::CH_W-1:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/acomp_front.sv -----
// first stage: coverage, divider numerator and initial remainder
`default_nettype none

module acomp_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    acomp_pix_if.sink        pixel,
    output acomp_pkg::stage_t out_data,
    output logic             out_valid,
    input  wire logic        out_ready
);

    logic                                  vld_reg;
    acomp_pkg::stage_t                     data_reg;
    acomp_pkg::stage_t                     data_next;
    logic                                  load;
    logic [acomp_pkg::ALPHA_W-1:0]         src_cov;
    logic [acomp_pkg::ALPHA_W-1:0]         blend;
    logic [acomp_pkg::NUM_W-1:0]           num;
    logic [acomp_pkg::CH_W-1:0]            inv_alpha;

    assign load        = !vld_reg || out_ready;
    assign pixel.ready = load;

    always_comb
    begin
        inv_alpha = acomp_pkg::FULL_ALPHA - pixel.src_opacity;
        // sa * 255 as a shift and subtract
        src_cov   = (acomp_pkg::ALPHA_W'(pixel.src_opacity) << acomp_pkg::CH_W)
                    - acomp_pkg::ALPHA_W'(pixel.src_opacity);
        blend     = acomp_pkg::ALPHA_W'(pixel.dst_alpha)
                    * acomp_pkg::ALPHA_W'(inv_alpha);
        num       = acomp_pkg::NUM_W'(pixel.src_opacity)
                    * acomp_pkg::NUM_W'(acomp_pkg::NUM_SCALE);

        data_next.s_red       = pixel.src_red;
        data_next.s_green     = pixel.src_green;
        data_next.s_blue      = pixel.src_blue;
        data_next.d_red       = pixel.dst_red;
        data_next.d_green     = pixel.dst_green;
        data_next.d_blue      = pixel.dst_blue;
        data_next.d_alpha     = pixel.dst_alpha;
        data_next.outa        = src_cov + blend;
        data_next.transparent = (pixel.src_opacity == '0);
        data_next.num_low     = num[acomp_pkg::COEF_W-1:0];
        // quotient fits in COEF_W bits, so the top part starts below the divisor
        data_next.rem         = num[acomp_pkg::NUM_W-1:acomp_pkg::COEF_W];
        data_next.quo         = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pixel.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_data  = data_reg;
    assign out_valid = vld_reg;

endmodule

`default_nettype wire

// ----- hdl/acomp_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module acomp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire acomp_pkg::stage_t in_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output acomp_pkg::stage_t      out_data,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    acomp_pkg::stage_t stg_reg [acomp_pkg::DIV_STAGES];
    logic              vld_reg [acomp_pkg::DIV_STAGES];
    logic              rdy     [acomp_pkg::DIV_STAGES+1];

    assign rdy[acomp_pkg::DIV_STAGES] = out_ready;
    assign in_ready                   = rdy[0];

    for (genvar k = 0; k < acomp_pkg::DIV_STAGES; k++)
    begin : g_stage
        acomp_pkg::stage_t             src;
        logic                          src_vld;
        acomp_pkg::stage_t             stg_next;
        logic [acomp_pkg::ALPHA_W:0]   trial;
        logic [acomp_pkg::ALPHA_W:0]   diff;
        logic                          ge;

        if (k == 0)
        begin : g_first
            assign src     = in_data;
            assign src_vld = in_valid;
        end
        else
        begin : g_rest
            assign src     = stg_reg[k-1];
            assign src_vld = vld_reg[k-1];
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_comb
        begin
            // bring down the next numerator bit, msb first
            trial    = {src.rem, src.num_low[acomp_pkg::DIV_STAGES-1-k]};
            diff     = trial - {1'b0, src.outa};
            ge       = (trial >= {1'b0, src.outa});
            stg_next = src;
            stg_next.rem = ge ? diff[acomp_pkg::ALPHA_W-1:0]
                              : trial[acomp_pkg::ALPHA_W-1:0];
            stg_next.quo = {src.quo[acomp_pkg::COEF_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_vld)
            begin
                stg_reg[k] <= stg_next;
            end
        end
    end

    assign out_data  = stg_reg[acomp_pkg::DIV_STAGES-1];
    assign out_valid = vld_reg[acomp_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/acomp_blend.sv -----
// weighted channel sums, divide-by-255 approximation and output register
`default_nettype none

module acomp_blend (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire acomp_pkg::stage_t in_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    acomp_res_if.source            result
);

    typedef struct packed {
        logic [acomp_pkg::PROD_W-1:0]  ps_red;
        logic [acomp_pkg::PROD_W-1:0]  ps_green;
        logic [acomp_pkg::PROD_W-1:0]  ps_blue;
        logic [acomp_pkg::PROD_W-1:0]  pd_red;
        logic [acomp_pkg::PROD_W-1:0]  pd_green;
        logic [acomp_pkg::PROD_W-1:0]  pd_blue;
        logic [acomp_pkg::CH_W-1:0]    d_red;
        logic [acomp_pkg::CH_W-1:0]    d_green;
        logic [acomp_pkg::CH_W-1:0]    d_blue;
        logic [acomp_pkg::CH_W-1:0]    d_alpha;
        logic [acomp_pkg::ALPHA_W-1:0] outa;
        logic                          transparent;
    } prod_t;

    typedef struct packed {
        logic [acomp_pkg::CH_W-1:0] red;
        logic [acomp_pkg::CH_W-1:0] green;
        logic [acomp_pkg::CH_W-1:0] blue;
        logic [acomp_pkg::CH_W-1:0] alpha;
    } pix_t;

    prod_t                          mult_reg;
    prod_t                          mult_next;
    logic                           prod_vld_reg;
    logic                           prod_load;
    pix_t                           res_reg;
    pix_t                           res_next;
    logic                           res_vld_reg;
    logic                           res_load;
    logic [acomp_pkg::COEF_W-1:0]   coef1;
    logic [acomp_pkg::COEF_W-1:0]   coef2;
    logic [acomp_pkg::ALPHA_W-1:0]  alpha_biased;
    logic [acomp_pkg::ALPHA_W-1:0]  alpha_adj;

    function automatic logic [acomp_pkg::CH_W-1:0] mix(
        input logic [acomp_pkg::PROD_W-1:0] ps,
        input logic [acomp_pkg::PROD_W-1:0] pd
    );
        logic [acomp_pkg::PROD_W-1:0] acc;
        logic [acomp_pkg::PROD_W-1:0] adj;
        acc = ps + pd + acomp_pkg::ROUND_BIAS;
        adj = acc + (acc >> acomp_pkg::CH_W);
        // divide by 256, then drop the fraction bits
        return adj[acomp_pkg::PROD_W-1:acomp_pkg::PROD_W-acomp_pkg::CH_W];
    endfunction

    assign res_load  = !res_vld_reg || result.ready;
    assign prod_load = !prod_vld_reg || res_load;
    assign in_ready  = prod_load;

    always_comb
    begin
        coef1 = in_data.quo;
        coef2 = acomp_pkg::COEF_FULL - coef1;
        mult_next.ps_red      = acomp_pkg::PROD_W'(in_data.s_red)
                                * acomp_pkg::PROD_W'(coef1);
        mult_next.ps_green    = acomp_pkg::PROD_W'(in_data.s_green)
                                * acomp_pkg::PROD_W'(coef1);
        mult_next.ps_blue     = acomp_pkg::PROD_W'(in_data.s_blue)
                                * acomp_pkg::PROD_W'(coef1);
        mult_next.pd_red      = acomp_pkg::PROD_W'(in_data.d_red)
                                * acomp_pkg::PROD_W'(coef2);
        mult_next.pd_green    = acomp_pkg::PROD_W'(in_data.d_green)
                                * acomp_pkg::PROD_W'(coef2);
        mult_next.pd_blue     = acomp_pkg::PROD_W'(in_data.d_blue)
                                * acomp_pkg::PROD_W'(coef2);
        mult_next.d_red       = in_data.d_red;
        mult_next.d_green     = in_data.d_green;
        mult_next.d_blue      = in_data.d_blue;
        mult_next.d_alpha     = in_data.d_alpha;
        mult_next.outa        = in_data.outa;
        mult_next.transparent = in_data.transparent;
    end

    always_comb
    begin
        alpha_biased = mult_reg.outa + acomp_pkg::ALPHA_W'(acomp_pkg::HALF_STEP);
        alpha_adj    = alpha_biased + (alpha_biased >> acomp_pkg::CH_W);
        if (mult_reg.transparent)
        begin
            // clear source: destination passes through
            res_next.red   = mult_reg.d_red;
            res_next.green = mult_reg.d_green;
            res_next.blue  = mult_reg.d_blue;
            res_next.alpha = mult_reg.d_alpha;
        end
        else
        begin
            res_next.red   = mix(mult_reg.ps_red,   mult_reg.pd_red);
            res_next.green = mix(mult_reg.ps_green, mult_reg.pd_green);
            res_next.blue  = mix(mult_reg.ps_blue,  mult_reg.pd_blue);
            res_next.alpha = alpha_adj[acomp_pkg::ALPHA_W-1:acomp_pkg::CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (prod_load)
            begin
                prod_vld_reg <= in_valid;
            end
            if (res_load)
            begin
                res_vld_reg <= prod_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load && in_valid)
        begin
            mult_reg <= mult_next;
        end
        if (res_load && prod_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid     = res_vld_reg;
    assign result.out_red   = res_reg.red;
    assign result.out_green = res_reg.green;
    assign result.out_blue  = res_reg.blue;
    assign result.out_alpha = res_reg.alpha;

endmodule

`default_nettype wire

// ----- hdl/alpha_composite_over_rgba8.sv -----
// top level of the source-over rgba8 compositor
`default_nettype none

// source-over compositing of one rgba8 source pixel onto one rgba8
// destination pixel. one pixel pair is taken and one result leaves per clock
// while the output is not stalled; the pipeline is 18 stages deep (1 front
// stage for coverage and numerator, 15 divider stages that each resolve one
// bit of the blend coefficient, 1 multiply stage, 1 sum and output register),
// and a result passes through each of these registers in that order before
// it can transfer out.
// a stall at the output backs up stage by stage: empty stages keep filling,
// and input ready drops only when every stage holds a pixel. a source alpha
// of zero returns the destination pixel unchanged. there is no
// configuration and no state carried between pixels.

module alpha_composite_over_rgba8 (
    input  wire logic   clk,
    input  wire logic   rst_n,
    acomp_pix_if.sink   pixel,
    acomp_res_if.source result
);

    // front stage to divider
    acomp_pkg::stage_t front_data;
    logic              front_valid;
    logic              front_ready;

    // divider to blend stages
    acomp_pkg::stage_t div_data;
    logic              div_valid;
    logic              div_ready;

    // coverage, outa255, numerator sa*255*255*128 and initial remainder
    acomp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .out_data  (front_data),
        .out_valid (front_valid),
        .out_ready (front_ready)
    );

    // coef1 = numerator / outa255, one quotient bit per stage
    acomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (front_data),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (div_data),
        .out_valid (div_valid),
        .out_ready (div_ready)
    );

    // weighted channel products, rounding and divide-by-255, output register
    acomp_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (div_data),
        .in_valid (div_valid),
        .in_ready (div_ready),
        .result   (result)
    );

endmodule

`default_nettype wire
